FILE: rtl/ipv6ap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipv6ap_pkg;

   localparam int CHAR_W  = 8;
   localparam int GROUP_W = 16;
   localparam int GROUPS  = 8;
   localparam int DIGITS  = 4;
   localparam int ADDR_W  = GROUP_W * GROUPS;
   localparam int HALF_W  = ADDR_W / 2;
   localparam int COUNT_W = $clog2(GROUPS + 1);
   localparam int DIGIT_W = $clog2(DIGITS + 1);
   localparam int NIBBLE_W = $clog2(GROUP_W);

   localparam logic [CHAR_W-1:0] COLON_CHAR = 8'h3A;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   // Hand-over from the character scanner to the result stage on the last character.
   typedef struct packed {
      logic               valid;
      logic               ok;
      logic [COUNT_W-1:0] gap_pos;
      logic [ADDR_W-1:0]  head;
      logic [ADDR_W-1:0]  tail;
   } done_type;

   // Decodes one hex digit in either case; letters have the low nibble one to six.
   function automatic hex_type hex_decode(input logic [CHAR_W-1:0] c);
      hex_type h;
      h.ok    = 1'b0;
      h.value = c[3:0];
      if (c >= "0" && c <= "9") begin
         h.ok = 1'b1;
      end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
         h.ok    = 1'b1;
         h.value = c[3:0] + 4'd9;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ipv6ap_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ipv6ap_req_if;
   import ipv6ap_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_byte;
   logic              last_char;

   modport source (output valid, output char_byte, output last_char, input ready);
   modport sink (input valid, input char_byte, input last_char, output ready);
endinterface

`default_nettype wire

FILE: rtl/ipv6ap_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ipv6ap_rsp_if;
   import ipv6ap_pkg::*;

   logic              valid;
   logic              ready;
   logic [HALF_W-1:0] addr_high;
   logic [HALF_W-1:0] addr_low;
   logic              addr_valid;

   modport source (output valid, output addr_high, output addr_low, output addr_valid,
                   input ready);
   modport sink (input valid, input addr_high, input addr_low, input addr_valid,
                 output ready);
endinterface

`default_nettype wire

FILE: rtl/ipv6_text_address_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// IPv6 address text parser.
// The req channel takes one character of the address text per item, with
// last_char set on the final character. The rsp channel gives one item per
// string: the 128-bit address as addr_high (groups 0..3) and addr_low (groups
// 4..7), and addr_valid; a rejected string gives zeros with addr_valid low.
// Each character goes into an input register and is scanned from there; the
// scan of the last character loads the result into the output register, where
// it waits until taken. One character is taken every cycle unless a last
// character stalls as below; the parse state updates once per character.
// While a result waits in the output register, characters of the next string
// keep flowing; only a last character stalls in the input register (ready
// low) until the waiting result is taken.
// Reset (synchronous, active high) empties both registers and returns the
// parser to the start of a string. After each last character the parser
// returns to the start on its own, whatever errors the string held.
module ipv6_text_address_parser (
   input  logic        clock,
   input  logic        reset,
   ipv6ap_req_if.sink  req_chan,
   ipv6ap_rsp_if.source rsp_chan
);
   import ipv6ap_pkg::*;

   done_type done;
   logic     hold;

   ipv6ap_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .hold     (hold),
      .done     (done)
   );

   ipv6ap_pack u_pack (
      .clock    (clock),
      .reset    (reset),
      .done     (done),
      .hold     (hold),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

FILE: rtl/ipv6ap_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv6ap_scan (
   input  logic                clock,
   input  logic                reset,
   ipv6ap_req_if.sink          req_chan,
   input  logic                hold,
   output ipv6ap_pkg::done_type done
);
   import ipv6ap_pkg::*;

   typedef enum logic [2:0] {
      PH_START,
      PH_LEAD,
      PH_GROUP,
      PH_COLON,
      PH_DOUBLE
   } phase_type;

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              last_ff, last_in;

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] gap_pos_ff, gap_pos_in;
   logic               gap_ff, gap_in;
   logic [GROUP_W-1:0] acc_ff, acc_in;
   logic [DIGIT_W-1:0] dcount_ff, dcount_in;
   logic               err_ff, err_in;
   logic [ADDR_W-1:0]  head_ff, head_in;
   logic [ADDR_W-1:0]  tail_ff, tail_in;

   logic               step;
   logic               colon;
   hex_type            hex;
   logic               do_start, do_close, do_double;
   logic               ok;
   logic [ADDR_W-1:0]  tail_fin;
   logic [COUNT_W-1:0] count_fin;

   // The character in the input register waits only when it closes a string and
   // the result stage is still holding the previous address.
   assign step           = in_valid_ff && !(last_ff && hold);
   assign req_chan.ready = !(in_valid_ff && last_ff && hold);

   always_comb begin
      in_valid_in = in_valid_ff;
      char_in     = char_ff;
      last_in     = last_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         char_in     = req_chan.char_byte;
         last_in     = req_chan.last_char;
      end
   end

   always_comb begin
      hex       = hex_decode(char_ff);
      colon     = (char_ff == COLON_CHAR);
      phase_in  = phase_ff;
      count_in  = count_ff;
      gap_pos_in = gap_pos_ff;
      gap_in    = gap_ff;
      acc_in    = acc_ff;
      dcount_in = dcount_ff;
      err_in    = err_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      do_start  = 1'b0;
      do_close  = 1'b0;
      do_double = 1'b0;

      if (step && !err_ff) begin
         case (phase_ff)
            PH_START: begin
               if (colon) begin
                  phase_in = PH_LEAD;
               end else if (hex.ok) begin
                  do_start = 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_LEAD: begin
               if (colon) begin
                  do_double = 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_GROUP: begin
               if (hex.ok) begin
                  if (dcount_ff >= DIGIT_W'(DIGITS)) begin
                     err_in = 1'b1;
                  end else begin
                     acc_in    = {acc_ff[GROUP_W-5:0], hex.value};
                     dcount_in = dcount_ff + 1'b1;
                  end
               end else if (colon) begin
                  do_close = 1'b1;
                  phase_in = PH_COLON;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_COLON: begin
               if (colon) begin
                  do_double = 1'b1;
               end else if (hex.ok) begin
                  do_start = 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end
            PH_DOUBLE: begin
               if (hex.ok) begin
                  do_start = 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end
            default: begin
               err_in = 1'b1;
            end
         endcase
      end

      if (do_start) begin
         if (count_ff >= COUNT_W'(GROUPS)) begin
            err_in = 1'b1;
         end else begin
            acc_in    = GROUP_W'(hex.value);
            dcount_in = DIGIT_W'(1);
            phase_in  = PH_GROUP;
         end
      end

      // Completed groups shift in at the bottom, so the newest is always lowest.
      if (do_close) begin
         tail_in   = {tail_ff[ADDR_W-GROUP_W-1:0], acc_ff};
         count_in  = count_ff + 1'b1;
         acc_in    = '0;
         dcount_in = '0;
      end

      // At the double colon the groups so far move aside; they are placed at
      // the top of the address once the string is complete.
      if (do_double) begin
         if (gap_ff) begin
            err_in = 1'b1;
         end else begin
            gap_in     = 1'b1;
            gap_pos_in = count_ff;
            head_in    = tail_ff;
            tail_in    = '0;
            phase_in   = PH_DOUBLE;
         end
      end

      ok        = !err_in;
      tail_fin  = tail_in;
      count_fin = count_in;
      if (ok) begin
         if (phase_in == PH_GROUP) begin
            tail_fin  = {tail_in[ADDR_W-GROUP_W-1:0], acc_in};
            count_fin = count_in + 1'b1;
         end else if (phase_in != PH_DOUBLE) begin
            ok = 1'b0;
         end
      end
      if (!gap_in && count_fin != COUNT_W'(GROUPS)) begin
         ok = 1'b0;
      end

      done.valid   = step && last_ff;
      done.ok      = ok;
      done.gap_pos = gap_pos_in;
      done.head    = head_in;
      done.tail    = tail_fin;

      if (step && last_ff) begin
         phase_in   = PH_START;
         count_in   = '0;
         gap_pos_in = '0;
         gap_in     = 1'b0;
         acc_in     = '0;
         dcount_in  = '0;
         err_in     = 1'b0;
         head_in    = '0;
         tail_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_START;
         count_ff    <= '0;
         gap_pos_ff  <= '0;
         gap_ff      <= 1'b0;
         acc_ff      <= '0;
         dcount_ff   <= '0;
         err_ff      <= 1'b0;
         head_ff     <= '0;
         tail_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         gap_pos_ff  <= gap_pos_in;
         gap_ff      <= gap_in;
         acc_ff      <= acc_in;
         dcount_ff   <= dcount_in;
         err_ff      <= err_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(GROUPS))
      else $error("group count above eight");

   a_gap_order : assert property (@(posedge clock) disable iff (reset)
      gap_ff |-> gap_pos_ff <= count_ff)
      else $error("double colon placed after the last group");

   a_string_restart : assert property (@(posedge clock) disable iff (reset)
      (step && last_ff) |=> (phase_ff == PH_START && count_ff == '0 && !err_ff && !gap_ff))
      else $error("parser not back at start after the last character");

   a_no_gap_no_head : assert property (@(posedge clock) disable iff (reset)
      !gap_ff |-> head_ff == '0)
      else $error("leading groups held without a double colon");
`endif

endmodule

`default_nettype wire

FILE: rtl/ipv6ap_pack.sv
`timescale 1ns / 1ps
`default_nettype none

module ipv6ap_pack (
   input  logic                 clock,
   input  logic                 reset,
   input  ipv6ap_pkg::done_type done,
   output logic                 hold,
   ipv6ap_rsp_if.source         rsp_chan
);
   import ipv6ap_pkg::*;

   localparam int SHIFT_W = $clog2(ADDR_W + 1);

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               ok_ff, ok_in;
   logic [COUNT_W-1:0] zero_groups;
   logic [SHIFT_W-1:0] head_shift;

   assign hold = rsp_valid_ff && !rsp_chan.ready;

   // The leading groups go to the top; the zero run of the double colon sits
   // between them and the trailing groups, which already lie at the bottom.
   always_comb begin
      zero_groups = COUNT_W'(GROUPS) - done.gap_pos;
      head_shift  = SHIFT_W'(zero_groups) << NIBBLE_W;
      addr_in     = addr_ff;
      ok_in       = ok_ff;
      if (done.valid) begin
         ok_in   = done.ok;
         addr_in = done.ok ? ((done.head << head_shift) | done.tail) : '0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (done.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      ok_ff   <= ok_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.addr_high  = addr_ff[ADDR_W-1:HALF_W];
   assign rsp_chan.addr_low   = addr_ff[HALF_W-1:0];
   assign rsp_chan.addr_valid = ok_ff;

`ifndef NO_ASSERTIONS
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      done.valid |-> !hold)
      else $error("new address arrived while the previous one was stalled");

   a_load_shows : assert property (@(posedge clock) disable iff (reset)
      done.valid |=> rsp_valid_ff)
      else $error("finished address not presented");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !ok_ff) |-> addr_ff == '0)
      else $error("rejected string carries a nonzero address");
`endif

endmodule

`default_nettype wire
